// File: rtl/apmq_pkg.sv
`timescale 1ns / 1ps

package apmq_pkg;

  // fixed field widths
  localparam int PAY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int QSIZE_W  = 5;

  // opcodes
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  // message kinds
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_ALARM  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALARM_BUSY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  // one result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                received_kind;
    logic [PAY_W-1:0]    received_payload;
    logic [QSIZE_W-1:0]  queue_size;
    logic                alarm_count;
  } res_t;

endpackage

// File: rtl/apmq_if.sv
`timescale 1ns / 1ps

// request channel
interface apmq_in_if import apmq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic             message_kind;
  logic             message_present;
  logic [PAY_W-1:0] message_payload;

  modport source (
    output valid, opcode, message_kind, message_present, message_payload,
    input  ready
  );
  modport sink (
    input  valid, opcode, message_kind, message_present, message_payload,
    output ready
  );
endinterface

// result channel
interface apmq_out_if import apmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                received_kind;
  logic [PAY_W-1:0]    received_payload;
  logic [QSIZE_W-1:0]  queue_size;
  logic                alarm_count;

  modport source (
    output valid, status, received_kind, received_payload, queue_size, alarm_count,
    input  ready
  );
  modport sink (
    input  valid, status, received_kind, received_payload, queue_size, alarm_count,
    output ready
  );
endinterface

// File: rtl/apmq_out_buf.sv
`timescale 1ns / 1ps

module apmq_out_buf import apmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  res_t        push_data,
  output logic        has_space,
  apmq_out_if.source  out_ch
);

  res_t       slot_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  res_t       head_data;

  assign pop       = out_ch.valid && out_ch.ready;
  assign has_space = (cnt_r != 2'd2);

  // pointer and fill update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push_valid) begin
      tail_nxt = ~tail_r;
    end
    if (pop) begin
      head_nxt = ~head_r;
    end
    if (push_valid && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result slots
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[tail_r] <= push_data;
    end
  end

  // head beat onto the port
  assign head_data               = slot_r[head_r];
  assign out_ch.valid            = (cnt_r != 2'd0);
  assign out_ch.status           = head_data.status;
  assign out_ch.received_kind    = head_data.received_kind;
  assign out_ch.received_payload = head_data.received_payload;
  assign out_ch.queue_size       = head_data.queue_size;
  assign out_ch.alarm_count      = head_data.alarm_count;

endmodule

// File: rtl/alarm_priority_message_queue_top.sv
`timescale 1ns / 1ps

// Message queue with one urgent slot.
// in_ch carries one request per beat: a send (normal message into the FIFO,
// or alarm into the single alarm slot) or a receive (alarm first, else the
// oldest normal message). out_ch returns exactly one result beat per request:
// status, the received message (zero unless a receive succeeded), and the
// number of held messages and alarms after the request.
// A send, a failed request or an alarm receive goes straight into the output
// buffer on acceptance. A receive from the FIFO first reads the store, which
// is a synchronous memory, and its result is pushed from the S_READ state;
// in_ch.ready is low in S_READ. Every other request can be accepted each
// cycle while the output buffer has space, so throughput is one request per
// cycle; after a FIFO receive no new request is taken until its result is pushed.
// Results pass through a two-beat output buffer; while the receiver stalls,
// requests are still taken until the buffer is full, then in_ch.ready drops.
// Reset (synchronous, rst_n low) empties the FIFO, the alarm slot and the
// output buffer; the FIFO store itself is not cleared and needs no sweep.
module alarm_priority_message_queue_top import apmq_pkg::*; #(
  parameter int NORMAL_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  apmq_in_if.sink    in_ch,
  apmq_out_if.source out_ch
);

  localparam int PTR_W = $clog2(NORMAL_DEPTH);
  localparam int CNT_W = $clog2(NORMAL_DEPTH + 1);
  localparam int LAST  = NORMAL_DEPTH - 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             alarm_valid_r, alarm_valid_nxt;
  logic [PAY_W-1:0] alarm_pay_r;
  res_t             pend_r;
  logic [PAY_W-1:0] rd_data_r;
  logic [PAY_W-1:0] store_mem [NORMAL_DEPTH];

  logic             accept;
  logic             buf_space;
  logic             do_push, do_pop, do_alarm_set, do_alarm_take;
  logic [CNT_W:0]   size_full;
  res_t             res_now;
  res_t             push_data;
  logic             push_valid;

  assign in_ch.ready = (state_r == S_IDLE) && buf_space;
  assign accept      = in_ch.valid && in_ch.ready;

  // request decode and status
  always_comb begin
    do_push       = 1'b0;
    do_pop        = 1'b0;
    do_alarm_set  = 1'b0;
    do_alarm_take = 1'b0;
    res_now       = '0;
    res_now.status = ST_OK;
    if (in_ch.opcode == OP_SEND) begin
      if (!in_ch.message_present) begin
        res_now.status = ST_NULL;
      end else if (in_ch.message_kind == KIND_ALARM) begin
        if (alarm_valid_r) begin
          res_now.status = ST_ALARM_BUSY;
        end else begin
          do_alarm_set = 1'b1;
        end
      end else if (cnt_r == CNT_W'(NORMAL_DEPTH)) begin
        res_now.status = ST_FULL;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (alarm_valid_r) begin
        do_alarm_take            = 1'b1;
        res_now.received_kind    = KIND_ALARM;
        res_now.received_payload = alarm_pay_r;
      end else if (cnt_r == '0) begin
        res_now.status = ST_EMPTY;
      end else begin
        do_pop                = 1'b1;
        res_now.received_kind = KIND_NORMAL;
      end
    end

    // state after this request
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    cnt_nxt         = cnt_r;
    alarm_valid_nxt = alarm_valid_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(LAST)) ? '0 : wr_ptr_r + 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(LAST)) ? '0 : rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
    if (do_alarm_set) begin
      alarm_valid_nxt = 1'b1;
    end
    if (do_alarm_take) begin
      alarm_valid_nxt = 1'b0;
    end

    size_full           = {1'b0, cnt_nxt} + (CNT_W + 1)'(alarm_valid_nxt);
    res_now.queue_size  = QSIZE_W'(size_full);
    res_now.alarm_count = alarm_valid_nxt;
  end

  // sequencer: a FIFO receive waits in S_READ for the store read
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && do_pop) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      cnt_r         <= '0;
      alarm_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        rd_ptr_r      <= rd_ptr_nxt;
        wr_ptr_r      <= wr_ptr_nxt;
        cnt_r         <= cnt_nxt;
        alarm_valid_r <= alarm_valid_nxt;
      end
    end
  end

  // alarm slot and pending result
  always_ff @(posedge clk) begin
    if (accept && do_alarm_set) begin
      alarm_pay_r <= in_ch.message_payload;
    end
    if (accept && do_pop) begin
      pend_r <= res_now;
    end
  end

  // FIFO store; one request at a time, so a write and a read never overlap
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      store_mem[wr_ptr_r] <= in_ch.message_payload;
    end
    if (accept && do_pop) begin
      rd_data_r <= store_mem[rd_ptr_r];
    end
  end

  // result into the output buffer
  always_comb begin
    push_data  = res_now;
    push_valid = accept && !do_pop;
    if (state_r == S_READ) begin
      push_data                  = pend_r;
      push_data.received_payload = rd_data_r;
      push_valid                 = 1'b1;
    end
  end

  apmq_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .has_space  (buf_space),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/apmq_checker.sv
`timescale 1ns / 1ps

module apmq_checker import apmq_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_received_kind,
  input logic [PAY_W-1:0]    out_received_payload,
  input logic [QSIZE_W-1:0]  out_queue_size,
  input logic                out_alarm_count
);

  // a stalled result beat stays and holds its status, payload and size
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_received_payload) && $stable(out_queue_size))
    else $error("result beat dropped or changed while stalled");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result beat present after reset");

  // a held alarm is counted in the total size
  a_size_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_count |-> out_queue_size != '0)
    else $error("alarm held but size is zero");

  // failed requests carry no message
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_received_payload == '0 && out_received_kind == KIND_NORMAL)
    else $error("message returned with an error status");

endmodule

bind alarm_priority_message_queue_top apmq_checker u_apmq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_status           (out_ch.status),
  .out_received_kind    (out_ch.received_kind),
  .out_received_payload (out_ch.received_payload),
  .out_queue_size       (out_ch.queue_size),
  .out_alarm_count      (out_ch.alarm_count)
);
